### design/grtb_pkg.sv
// Shared types and constants for the gradient ramp table builder.
`default_nettype none
package grtb_pkg;

  localparam int NUM_CHAN  = 4;
  localparam int CHAN_W    = 17;
  localparam int FRAC_W    = 16;
  localparam int DIFF_W    = CHAN_W + 1;
  localparam int DELTA_W   = CHAN_W + FRAC_W + 1;
  localparam int ACC_W     = DELTA_W + 1;
  localparam int DIV_STEPS = CHAN_W + FRAC_W;
  localparam int STEP_W    = 6;

  typedef logic [CHAN_W-1:0]         chan_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [DELTA_W-1:0] delta_t;
  typedef logic signed [ACC_W-1:0]   acc_t;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_DIV,
    S_FILL
  } state_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [16:0] position;
    logic [16:0] red;
    logic [16:0] green;
    logic [16:0] blue;
    logic [16:0] alpha;
    logic [7:0]  read_index;
  } item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
  } result_t;

  // Converts an accumulator (32 fraction bits) to a byte: (acc * 255) >> 32,
  // clamped to 0..255.
  function automatic logic [7:0] to_byte(input acc_t acc);
    logic [ACC_W+7:0] prod;
    logic [ACC_W-25:0] v;
    prod = {1'b0, acc[ACC_W-2:0], 8'd0} - (ACC_W+8)'(acc[ACC_W-2:0]);
    v = prod[ACC_W+7:32];
    if (acc <= 0) begin
      to_byte = 8'd0;
    end else if (v > (ACC_W-24)'(255)) begin
      to_byte = 8'hFF;
    end else begin
      to_byte = v[7:0];
    end
  endfunction

endpackage
`default_nettype wire

### design/grtb_div.sv
// Four-lane restoring divider that forms the per-entry channel deltas.
`default_nettype none
module grtb_div #(
  parameter int IW = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [IW-1:0]        span,
  input  wire grtb_pkg::diff_t      diff [grtb_pkg::NUM_CHAN],
  output logic                      done,
  output grtb_pkg::delta_t          delta [grtb_pkg::NUM_CHAN]
);
  import grtb_pkg::*;

  localparam int NUM_W = CHAN_W + FRAC_W;

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [IW-1:0]     divisor;
  logic [NUM_W-1:0]  num [NUM_CHAN];
  logic [NUM_W-1:0]  quo [NUM_CHAN];
  logic [IW:0]       rem [NUM_CHAN];
  logic              neg [NUM_CHAN];

  logic [IW:0]       rem_shift [NUM_CHAN];
  logic              ge        [NUM_CHAN];
  logic [DIFF_W-1:0] mag       [NUM_CHAN];

  always_comb begin
    for (int k = 0; k < NUM_CHAN; k++) begin
      rem_shift[k] = {rem[k][IW-1:0], num[k][NUM_W-1]};
      ge[k]        = rem_shift[k] >= {1'b0, divisor};
      mag[k]       = diff[k][DIFF_W-1] ? DIFF_W'(-diff[k]) : DIFF_W'(diff[k]);
      delta[k]     = neg[k] ? -$signed({1'b0, quo[k]}) : $signed({1'b0, quo[k]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && (step == STEP_W'(DIV_STEPS - 1));
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // The dividend's low fraction bits are zero, so the magnitude is shifted in
  // once at start and one quotient bit is settled per cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      divisor <= span;
      for (int k = 0; k < NUM_CHAN; k++) begin
        num[k] <= {mag[k][CHAN_W-1:0], FRAC_W'(0)};
        quo[k] <= '0;
        rem[k] <= '0;
        neg[k] <= diff[k][DIFF_W-1];
      end
    end else if (busy) begin
      for (int k = 0; k < NUM_CHAN; k++) begin
        num[k] <= num[k] << 1;
        quo[k] <= {quo[k][NUM_W-2:0], ge[k]};
        rem[k] <= ge[k] ? (rem_shift[k] - {1'b0, divisor}) : rem_shift[k];
      end
    end
  end

endmodule
`default_nettype wire

### design/gradient_ramp_table_builder.sv
// Top level of the gradient ramp table builder.
// Builds a table of TABLE_ENTRIES RGBA8 entries from color stops and holds it in
// one synchronous RAM with a write port and a read port. After reset, and after
// every clear beat, the table is swept to zero one entry per cycle while no item
// is taken. The first stop after a clear records only its color; the previous
// index stays zero. A later stop whose index lies beyond the previous index runs a
// four-lane divider and then writes span + 1 entries, one per cycle; other stops
// only update the previous index and color. A read beat passes through the RAM
// read register and then the output register, where its result waits while
// later beats are accepted.
`default_nettype none
module gradient_ramp_table_builder #(
  parameter int TABLE_ENTRIES = 256
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire grtb_pkg::item_t   item,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output grtb_pkg::result_t      result
);
  import grtb_pkg::*;

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int PW = CHAN_W + IW;

  typedef logic [IW-1:0] idx_t;

  // Table storage.
  logic [31:0] ramp_mem [TABLE_ENTRIES];
  logic [31:0] rd_data;
  logic        rd_oob;

  state_t state, state_next;

  logic        have_stop;
  idx_t        prev_index;
  chan_t       prev_color [NUM_CHAN];
  idx_t        clr_cnt;
  idx_t        fill_addr;
  idx_t        fill_end;
  acc_t        acc [NUM_CHAN];

  logic        accept;
  logic        is_clear, is_stop, is_read;
  logic        grow;
  logic [PW-1:0] prod;
  logic [IW:0]   quot_idx;
  idx_t        stop_idx;
  chan_t       stop_color [NUM_CHAN];
  diff_t       diff [NUM_CHAN];
  delta_t      delta [NUM_CHAN];
  logic        div_start;
  logic        div_done;
  logic        load_result;
  logic        mem_we;
  idx_t        mem_waddr;
  logic [31:0] mem_wdata;
  logic [31:0] fill_word;

  assign accept   = item_valid && !item_stall;
  assign is_clear = item.cmd == CMD_CLEAR;
  assign is_stop  = item.cmd == CMD_STOP;
  assign is_read  = item.cmd == CMD_READ;

  always_comb begin
    stop_color[0] = item.red;
    stop_color[1] = item.green;
    stop_color[2] = item.blue;
    stop_color[3] = item.alpha;
    prod     = PW'(item.position) * PW'(TABLE_ENTRIES);
    quot_idx = prod[PW-1:FRAC_W];
    if (quot_idx > (IW+1)'(TABLE_ENTRIES - 1)) begin
      stop_idx = IW'(TABLE_ENTRIES - 1);
    end else begin
      stop_idx = quot_idx[IW-1:0];
    end
    grow = have_stop && (stop_idx > prev_index);
    for (int k = 0; k < NUM_CHAN; k++) begin
      diff[k] = $signed({1'b0, stop_color[k]}) - $signed({1'b0, prev_color[k]});
      fill_word[8*k +: 8] = to_byte(acc[k]);
    end
  end

  grtb_div #(
    .IW(IW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .span  (stop_idx - prev_index),
    .diff  (diff),
    .done  (div_done),
    .delta (delta)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_cnt == IW'(TABLE_ENTRIES - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          priority if (is_clear) begin
            state_next = S_CLEAR;
          end else if (is_read) begin
            state_next = S_READ;
          end else if (is_stop && grow) begin
            state_next = S_DIV;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_READ: begin
        if (!result_valid || !result_stall) begin
          state_next = S_IDLE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_FILL;
        end
      end
      S_FILL: begin
        if (fill_addr == fill_end) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    item_stall  = 1'b1;
    div_start   = 1'b0;
    load_result = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = fill_addr;
    mem_wdata   = fill_word;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = '0;
      end
      S_IDLE: begin
        item_stall = 1'b0;
        div_start  = accept && is_stop && grow;
      end
      S_READ: begin
        load_result = !result_valid || !result_stall;
      end
      S_DIV: begin
      end
      S_FILL: begin
        mem_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ramp_mem[mem_waddr] <= mem_wdata;
    end
    if (accept && is_read) begin
      rd_data <= ramp_mem[IW'(item.read_index)];
      rd_oob  <= 32'(item.read_index) >= TABLE_ENTRIES;
    end
  end

  // Stop bookkeeping and the clearing sweep.
  always_ff @(posedge clk) begin
    if (rst) begin
      have_stop  <= 1'b0;
      prev_index <= '0;
      clr_cnt    <= '0;
      for (int k = 0; k < NUM_CHAN; k++) begin
        prev_color[k] <= '0;
      end
    end else begin
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (accept && is_clear) begin
        have_stop  <= 1'b0;
        prev_index <= '0;
        clr_cnt    <= '0;
        for (int k = 0; k < NUM_CHAN; k++) begin
          prev_color[k] <= '0;
        end
      end else if (accept && is_stop) begin
        have_stop <= 1'b1;
        if (have_stop) begin
          prev_index <= stop_idx;
        end
        for (int k = 0; k < NUM_CHAN; k++) begin
          prev_color[k] <= stop_color[k];
        end
      end
    end
  end

  // Segment fill: the accumulators start at the previous stop's color and
  // step by the divider's deltas after each entry is written.
  always_ff @(posedge clk) begin
    if (div_start) begin
      fill_addr <= prev_index;
      fill_end  <= stop_idx;
      for (int k = 0; k < NUM_CHAN; k++) begin
        acc[k] <= {2'b00, prev_color[k], FRAC_W'(0)};
      end
    end else if (state == S_FILL) begin
      fill_addr <= fill_addr + 1'b1;
      for (int k = 0; k < NUM_CHAN; k++) begin
        acc[k] <= acc[k] + ACC_W'(delta[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_result) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      result.out_red   <= rd_oob ? 8'd0 : rd_data[7:0];
      result.out_green <= rd_oob ? 8'd0 : rd_data[15:8];
      result.out_blue  <= rd_oob ? 8'd0 : rd_data[23:16];
      result.out_alpha <= rd_oob ? 8'd0 : rd_data[31:24];
    end
  end

endmodule
`default_nettype wire
